[rtl/pcfm_pkg.sv]
// ----------------------------------------------------------------------------
// pcfm_pkg
// shared types, register codes and reset values for the four-mode pi controller
// ----------------------------------------------------------------------------
package pcfm_pkg;

  localparam int DATA_W             = 24;
  localparam int LIM_W              = DATA_W - 1;
  localparam int GAIN_W             = 16;
  localparam int MODE_W             = 2;
  localparam int CFG_IDX_W          = 3;
  localparam int GAIN_FRAC_BITS_DEF = 12;

  typedef enum logic [MODE_W-1:0] {
    MODE_CURRENT  = 2'd0,
    MODE_SPEED    = 2'd1,
    MODE_POSITION = 2'd2,
    MODE_DYNAMIC  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_OUT_MIN      = 3'd3,
    REG_OUT_MAX      = 3'd4,
    REG_DEADBAND     = 3'd5,
    REG_ERROR_LIMIT  = 3'd6,
    REG_INTEG_WINDOW = 3'd7
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0]        PROP_GAIN_RST    = GAIN_W'(4096);
  localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST   = '0;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST      = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST      = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [LIM_W-1:0]         DEADBAND_RST     = LIM_W'(768);
  localparam logic [LIM_W-1:0]         ERROR_LIMIT_RST  = LIM_W'(6400);
  localparam logic [LIM_W-1:0]         INTEG_WINDOW_RST = LIM_W'(1280);

  typedef struct packed {
    mode_e                     mode;
    logic [GAIN_W-1:0]         prop_gain;
    logic [GAIN_W-1:0]         integ_gain;
    logic signed [DATA_W-1:0]  out_min;
    logic signed [DATA_W-1:0]  out_max;
    logic [LIM_W-1:0]          deadband;
    logic [LIM_W-1:0]          error_limit;
    logic [LIM_W-1:0]          integ_window;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] reference;
    logic signed [DATA_W-1:0] feedback;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] error_term;
    logic signed [DATA_W-1:0] integral_term;
  } out_beat_t;

endpackage

[rtl/pcfm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pcfm_cfg_regs
// configuration register file, write only, masked to each register width
// ----------------------------------------------------------------------------
module pcfm_cfg_regs
  import pcfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] idx_i,
  input  logic [DATA_W-1:0]    data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= MODE_CURRENT;
      cfg_q.prop_gain    <= PROP_GAIN_RST;
      cfg_q.integ_gain   <= INTEG_GAIN_RST;
      cfg_q.out_min      <= OUT_MIN_RST;
      cfg_q.out_max      <= OUT_MAX_RST;
      cfg_q.deadband     <= DEADBAND_RST;
      cfg_q.error_limit  <= ERROR_LIMIT_RST;
      cfg_q.integ_window <= INTEG_WINDOW_RST;
    end else if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        REG_MODE:         cfg_q.mode         <= mode_e'(data_i[MODE_W-1:0]);
        REG_PROP_GAIN:    cfg_q.prop_gain    <= data_i[GAIN_W-1:0];
        REG_INTEG_GAIN:   cfg_q.integ_gain   <= data_i[GAIN_W-1:0];
        REG_OUT_MIN:      cfg_q.out_min      <= signed'(data_i);
        REG_OUT_MAX:      cfg_q.out_max      <= signed'(data_i);
        REG_DEADBAND:     cfg_q.deadband     <= data_i[LIM_W-1:0];
        REG_ERROR_LIMIT:  cfg_q.error_limit  <= data_i[LIM_W-1:0];
        REG_INTEG_WINDOW: cfg_q.integ_window <= data_i[LIM_W-1:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/pcfm_err.sv]
// ----------------------------------------------------------------------------
// pcfm_err
// error stage: saturated reference minus feedback, speed mode clamp
// ----------------------------------------------------------------------------
module pcfm_err
  import pcfm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  in_beat_t                 data_i,
  input  cfg_t                     cfg_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] err_o
);

  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W-1:0] err_sat;
  logic signed [DATA_W-1:0] lim_pos;
  logic signed [DATA_W-1:0] lim_neg;
  logic signed [DATA_W-1:0] err_d;
  logic signed [DATA_W-1:0] err_q;
  logic                     valid_q;

  always_comb begin
    diff = {data_i.reference[DATA_W-1], data_i.reference}
         - {data_i.feedback[DATA_W-1], data_i.feedback};
    // saturate on overflow into the extra sign bit
    if (diff[DATA_W] != diff[DATA_W-1]) begin
      err_sat = {diff[DATA_W], {(DATA_W-1){~diff[DATA_W]}}};
    end else begin
      err_sat = diff[DATA_W-1:0];
    end
    lim_pos = signed'({1'b0, cfg_i.error_limit});
    lim_neg = -lim_pos;
    err_d   = err_sat;
    if (cfg_i.mode == MODE_SPEED) begin
      if (err_d > lim_pos) err_d = lim_pos;
      if (err_d < lim_neg) err_d = lim_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      err_q <= err_d;
    end
  end

  assign valid_o = valid_q;
  assign err_o   = err_q;

endmodule

[rtl/pcfm_mult.sv]
// ----------------------------------------------------------------------------
// pcfm_mult
// gain stage: proportional and integral products, current mode deadband
// ----------------------------------------------------------------------------
module pcfm_mult
  import pcfm_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int PROD_W        = DATA_W + GAIN_W + 1,
  localparam int PW            = PROD_W - GAIN_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] err_i,
  input  cfg_t                     cfg_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] err_o,
  output logic signed [PW-1:0]     p_o,
  output logic signed [PW-1:0]     inc_o
);

  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PW-1:0]     p_d;
  logic signed [PW-1:0]     inc_d;
  logic signed [DATA_W-1:0] band;
  logic                     in_band;
  logic signed [PW-1:0]     p_q;
  logic signed [PW-1:0]     inc_q;
  logic signed [DATA_W-1:0] err_q;
  logic                     valid_q;

  always_comb begin
    prod_p  = $signed({1'b0, cfg_i.prop_gain}) * err_i;
    prod_i  = $signed({1'b0, cfg_i.integ_gain}) * err_i;
    // dropping the low bits floors toward minus infinity
    inc_d   = prod_i[PROD_W-1:GAIN_FRAC_BITS];
    band    = signed'({1'b0, cfg_i.deadband});
    in_band = (err_i > -band) && (err_i < band);
    if ((cfg_i.mode == MODE_CURRENT) && in_band) begin
      p_d = '0;
    end else begin
      p_d = prod_p[PROD_W-1:GAIN_FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      p_q   <= p_d;
      inc_q <= inc_d;
      err_q <= err_i;
    end
  end

  assign valid_o = valid_q;
  assign err_o   = err_q;
  assign p_o     = p_q;
  assign inc_o   = inc_q;

endmodule

[rtl/pcfm_integ.sv]
// ----------------------------------------------------------------------------
// pcfm_integ
// integrator update with mode limits, output clamp and result register
// ----------------------------------------------------------------------------
module pcfm_integ
  import pcfm_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int PW            = DATA_W + GAIN_W + 1 - GAIN_FRAC_BITS,
  localparam int SW            = PW + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] err_i,
  input  logic signed [PW-1:0]     p_i,
  input  logic signed [PW-1:0]     inc_i,
  input  cfg_t                     cfg_i,
  output logic                     out_valid_o,
  output out_beat_t                out_data_o
);

  logic signed [DATA_W-1:0] integ_q;
  logic signed [SW-1:0]     sum;
  logic signed [SW-1:0]     p_x;
  logic signed [SW-1:0]     abs_p;
  logic signed [SW-1:0]     lim;
  logic signed [SW-1:0]     lo;
  logic signed [SW-1:0]     hi;
  logic signed [SW-1:0]     clamped;
  logic signed [DATA_W-1:0] win;
  logic                     upd;
  logic signed [DATA_W-1:0] ui;
  logic signed [SW-1:0]     drv_sum;
  logic signed [SW-1:0]     drv;
  out_beat_t                out_d;
  out_beat_t                out_q;
  logic                     out_valid_q;

  always_comb begin
    sum   = SW'(inc_i) + SW'(integ_q);
    p_x   = SW'(p_i);
    abs_p = (p_x < 0) ? -p_x : p_x;
    lim   = SW'(cfg_i.out_max) - abs_p;
    if (lim < 0) lim = '0;
    if (cfg_i.mode == MODE_DYNAMIC) begin
      hi = lim;
      lo = -lim;
    end else begin
      hi = SW'(cfg_i.out_max);
      lo = SW'(cfg_i.out_min);
    end
    // upper bound first, so the lower one wins when crossed
    clamped = sum;
    if (clamped > hi) clamped = hi;
    if (clamped < lo) clamped = lo;

    win = signed'({1'b0, cfg_i.integ_window});
    upd = (cfg_i.mode != MODE_POSITION) || ((integ_q < win) && (integ_q > -win));
    ui  = upd ? clamped[DATA_W-1:0] : integ_q;

    drv_sum = p_x + SW'(ui);
    drv     = drv_sum;
    if (drv > SW'(cfg_i.out_max)) drv = SW'(cfg_i.out_max);
    if (drv < SW'(cfg_i.out_min)) drv = SW'(cfg_i.out_min);

    out_d.drive         = drv[DATA_W-1:0];
    out_d.error_term    = err_i;
    out_d.integral_term = ui;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integ_q     <= '0;
    end else if (adv_i) begin
      out_valid_q <= valid_i;
      if (valid_i) begin
        integ_q <= ui;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // integrator moves only with a beat passing through
  a_integ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv_i && valid_i) |=> $stable(integ_q))
    else $error("integrator changed without a beat");

  // a held result reports the current integrator
  a_integ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.integral_term == integ_q))
    else $error("integral_term differs from integrator");

  // a beat entering this stage leaves a result behind
  a_result_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && valid_i) |=> out_valid_q)
    else $error("beat lost in integrator stage");

endmodule

[rtl/pi_controller_four_mode.sv]
// ----------------------------------------------------------------------------
// pi_controller_four_mode
// pi controller with anti-windup and four selectable limit modes
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_stall_o is low and returns each result
// through the error, gain multiply and integrator stage registers. The
// integrator closes its loop within the last stage, which sets the sustained
// rate of one beat per cycle. When the result register is held by out_stall_i
// the whole pipeline holds and in_stall_o rises. The user must write registers
// through the cfg port only while no beat is in flight; the block never checks.
module pi_controller_four_mode
  import pcfm_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int PW = DATA_W + GAIN_W + 1 - GAIN_FRAC_BITS;

  cfg_t                     cfg;
  logic                     adv;
  logic                     err_valid;
  logic signed [DATA_W-1:0] err;
  logic                     mul_valid;
  logic signed [DATA_W-1:0] mul_err;
  logic signed [PW-1:0]     p_term;
  logic signed [PW-1:0]     inc_term;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  pcfm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  pcfm_err u_err (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg),
    .valid_o (err_valid),
    .err_o   (err)
  );

  pcfm_mult #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (err_valid),
    .err_i   (err),
    .cfg_i   (cfg),
    .valid_o (mul_valid),
    .err_o   (mul_err),
    .p_o     (p_term),
    .inc_o   (inc_term)
  );

  pcfm_integ #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (mul_valid),
    .err_i       (mul_err),
    .p_i         (p_term),
    .inc_i       (inc_term),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
